[design/cdad_pkg.sv]
// ----------------------------------------------------------------------------
// cdad_pkg: shared constants and helpers for the calendar date add core
// Era / day-of-era constants, reciprocal multipliers for the constant
// divisions, and the March-based month start table.
// ----------------------------------------------------------------------------
package cdad_pkg;

  // Pipeline depth: input register through result register
  localparam int STAGES = 10;

  // Days in one 400-year Gregorian era
  localparam logic [17:0] ERA_DAYS = 18'd146097;

  // Year bias so that floor(year / 400) becomes an unsigned divide.
  // 83 eras cover the lowest adjusted year of -32769.
  localparam int unsigned ERA_BIAS_IN_N  = 83;
  localparam logic signed [16:0] YEAR_BIAS = 17'sd33200;   // 83 * 400

  // Era bias on the serial side; 90 eras cover the lowest serial day.
  localparam int unsigned ERA_BIAS_OUT_N = 90;
  localparam logic [24:0] ERA_BIAS_STEP  = 25'(ERA_BIAS_OUT_N - ERA_BIAS_IN_N);
  localparam logic [17:0] YEAR_BASE_OUT  = 18'(ERA_BIAS_OUT_N * 400);

  // Reciprocals, rounded up: x / D == (x * R) >> K over the used range
  localparam longint unsigned R25_FULL   = ((64'd1 << 17) + 64'd24) / 64'd25;
  localparam longint unsigned RERA_FULL  = ((64'd1 << 43) + 64'd146096) / 64'd146097;
  localparam longint unsigned R1460_FULL = ((64'd1 << 25) + 64'd364) / 64'd365;
  localparam longint unsigned R365_FULL  = ((64'd1 << 27) + 64'd364) / 64'd365;

  localparam logic [12:0] RECIP_25   = 13'(R25_FULL);    // (u >> 4) / 25
  localparam logic [25:0] RECIP_ERA  = 26'(RERA_FULL);   // / 146097, shift 43
  localparam logic [16:0] RECIP_1460 = 17'(R1460_FULL);  // (doe >> 2) / 365
  localparam logic [18:0] RECIP_365  = 19'(R365_FULL);   // / 365, shift 27

  // Days in one Gregorian century; its multiples are the day-of-era thresholds for the century rule
  localparam logic [17:0] CENT_DAYS = 18'd36524;

  // First day of each March-based month within the year, (153*mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // yoe / 100 for a year of era below 400
  function automatic logic [1:0] div100(input logic [8:0] yoe);
    logic [1:0] r;
    r = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    return r;
  endfunction

endpackage

[design/calendar_date_add_days_core.sv]
// 10 register stages, input register through result register. Throughput: one
// item per cycle while out_stall is low; the stages hold one item each and close up
// bubbles, so input is taken while a finished result waits at the output as long
// as a stage is empty. The depth comes from giving each of the four reciprocal
// multiplies and the remainder steps that follow them a stage of their own.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// calendar_date_add_days_core: proleptic Gregorian date plus signed day offset
// Date -> serial day (era / day-of-era), add offset, serial -> date. Year
// results beyond 16 bits wrap and raise year_overflow.
// ----------------------------------------------------------------------------
module calendar_date_add_days_core (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [20:0] delta_days,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic               year_overflow
);

  localparam int NS = cdad_pkg::STAGES;

  // --------------------------------------------------------------------------
  // Flow control. Stage k may load when it is empty or when every stage
  // downstream can move, i.e. the result is leaving or a hole exists at or
  // after k. Each term is an independent reduction, no ripple chain.
  // --------------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = !out_stall || (|(~v >> k));
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic signed [15:0] s0_year;
  logic [3:0]         s0_month;
  logic [4:0]         s0_day;
  logic signed [20:0] s0_delta;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_year  <= year_in;
      s0_month <= month_in;
      s0_day   <= day_in;
      s0_delta <= delta_days;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: March-based year, biased year, era = floor(year / 400).
  // Jan/Feb (and month 0) belong to the previous March-based year.
  // --------------------------------------------------------------------------
  logic               early;
  logic signed [16:0] year_adj;
  logic [16:0]        yb;
  logic [3:0]         mp_in;
  logic signed [9:0]  doy_in;
  logic [25:0]        q_prod;

  always_comb begin
    early    = (s0_month <= 4'd2);
    year_adj = early ? 17'(s0_year) - 17'sd1 : 17'(s0_year);
    yb       = 17'(year_adj + cdad_pkg::YEAR_BIAS);
    mp_in    = early ? s0_month + 4'd9 : s0_month - 4'd3;
    // day 0 lands one day before the first of the month
    doy_in   = $signed({1'b0, cdad_pkg::month_start(mp_in)})
             + $signed({5'b0, s0_day}) - 10'sd1;
    q_prod   = 26'(yb[16:4]) * 26'(cdad_pkg::RECIP_25);
  end

  logic [7:0]         s1_q;
  logic [16:0]        s1_yb;
  logic signed [9:0]  s1_doy;
  logic signed [20:0] s1_delta;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_q     <= q_prod[24:17];
      s1_yb    <= yb;
      s1_doy   <= doy_in;
      s1_delta <= s0_delta;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: year of era
  // --------------------------------------------------------------------------
  logic [8:0] yoe;

  assign yoe = 9'(s1_yb - 17'(s1_q) * 17'd400);

  logic [7:0]         s2_q;
  logic [8:0]         s2_yoe;
  logic signed [9:0]  s2_doy;
  logic signed [20:0] s2_delta;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_q     <= s1_q;
      s2_yoe   <= yoe;
      s2_doy   <= s1_doy;
      s2_delta <= s1_delta;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: day of era, then the biased serial day with the offset added.
  // The epoch shift cancels between the two conversions, so it never
  // appears; the era bias moves from 83 to 90 eras here.
  // --------------------------------------------------------------------------
  logic [17:0] yoe_days;
  logic [24:0] eoff;
  logic [26:0] u2_sum;

  always_comb begin
    yoe_days = 18'(s2_yoe) * 18'd365 + 18'(s2_yoe[8:2])
             - 18'(cdad_pkg::div100(s2_yoe));
    eoff     = (25'(s2_q) + cdad_pkg::ERA_BIAS_STEP) * 25'(cdad_pkg::ERA_DAYS);
    u2_sum   = 27'(eoff) + 27'(yoe_days) + 27'(s2_doy) + 27'(s2_delta);
  end

  logic [24:0] s3_u2;

  always_ff @(posedge clk) begin
    if (adv[3]) s3_u2 <= u2_sum[24:0];
  end

  // --------------------------------------------------------------------------
  // Stage 4: era of the result (biased by 90)
  // --------------------------------------------------------------------------
  logic [50:0] era_prod;

  assign era_prod = 51'(s3_u2) * 51'(cdad_pkg::RECIP_ERA);

  logic [7:0]  s4_q2;
  logic [24:0] s4_u2;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_q2 <= era_prod[50:43];
      s4_u2 <= s3_u2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: day of era of the result
  // --------------------------------------------------------------------------
  logic [17:0] doe2;

  assign doe2 = 18'(s4_u2 - 25'(s4_q2) * 25'(cdad_pkg::ERA_DAYS));

  logic [7:0]  s5_q2;
  logic [17:0] s5_doe2;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_q2   <= s4_q2;
      s5_doe2 <= doe2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: leap correction doe - doe/1460 + doe/36524 - doe/146096.
  // The last day of an era (leap day of the 400th year) is the only one
  // that divides to 1 by 146096.
  // --------------------------------------------------------------------------
  logic [32:0] lp_prod;
  logic [6:0]  n_quad;
  logic [2:0]  n_cent;
  logic        last_day;
  logic [17:0] t_days;

  always_comb begin
    lp_prod  = 33'(s5_doe2[17:2]) * 33'(cdad_pkg::RECIP_1460);
    n_quad   = lp_prod[31:25];
    n_cent   = 3'(s5_doe2 >= cdad_pkg::CENT_DAYS)
             + 3'(s5_doe2 >= 18'(2 * cdad_pkg::CENT_DAYS))
             + 3'(s5_doe2 >= 18'(3 * cdad_pkg::CENT_DAYS))
             + 3'(s5_doe2 >= 18'(4 * cdad_pkg::CENT_DAYS));
    last_day = (s5_doe2 == 18'(4 * cdad_pkg::CENT_DAYS));
    t_days   = s5_doe2 - 18'(n_quad) + 18'(n_cent) - 18'(last_day);
  end

  logic [7:0]  s6_q2;
  logic [17:0] s6_doe2;
  logic [17:0] s6_t;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_q2   <= s5_q2;
      s6_doe2 <= s5_doe2;
      s6_t    <= t_days;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: year of era of the result
  // --------------------------------------------------------------------------
  logic [36:0] yr_prod;

  assign yr_prod = 37'(s6_t) * 37'(cdad_pkg::RECIP_365);

  logic [7:0]  s7_q2;
  logic [17:0] s7_doe2;
  logic [8:0]  s7_yoe2;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_q2   <= s6_q2;
      s7_doe2 <= s6_doe2;
      s7_yoe2 <= yr_prod[35:27];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: day of March-based year, and the biased year sum
  // --------------------------------------------------------------------------
  logic [17:0] year_days2;
  logic [8:0]  doy2;
  logic [16:0] ysum;

  always_comb begin
    year_days2 = 18'(s7_yoe2) * 18'd365 + 18'(s7_yoe2[8:2])
               - 18'(cdad_pkg::div100(s7_yoe2));
    doy2       = 9'(s7_doe2 - year_days2);
    ysum       = 17'(s7_q2) * 17'd400 + 17'(s7_yoe2);
  end

  logic [8:0]  s8_doy2;
  logic [16:0] s8_ysum;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_doy2 <= doy2;
      s8_ysum <= ysum;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: month search, day, calendar year, overflow; result register
  // --------------------------------------------------------------------------
  logic [3:0]         mp;
  logic               late;
  logic signed [17:0] year_full;
  logic [4:0]         day_calc;
  logic [3:0]         month_calc;
  logic               ovf_calc;

  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s8_doy2 >= cdad_pkg::month_start(4'(k))) mp = 4'(k);
    end
    day_calc   = 5'(s8_doy2 - cdad_pkg::month_start(mp) + 9'd1);
    late       = (mp >= 4'd10);                  // January or February
    month_calc = late ? mp - 4'd9 : mp + 4'd3;
    year_full  = 18'(s8_ysum) - cdad_pkg::YEAR_BASE_OUT + 18'(late);
    ovf_calc   = (year_full[17:15] != 3'b000) && (year_full[17:15] != 3'b111);
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      year_out      <= year_full[15:0];
      month_out     <= month_calc;
      day_out       <= day_calc;
      year_overflow <= ovf_calc;
    end
  end

`ifndef ASSERT_OFF
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_out >= 4'd1 && month_out <= 4'd12)
    else $error("month_out out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> day_out >= 5'd1 && day_out <= 5'd31)
    else $error("day_out out of range");

  a_feb_days: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_out == 4'd2 |-> day_out <= 5'd29)
    else $error("February day past 29");

  a_ovf_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && year_overflow |-> year_out < -16'sd28000 || year_out > 16'sd28000)
    else $error("overflow flagged for an in-range year");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
